@@ rtl/cds_pkg.sv @@
// cds_pkg: shared constants, types and the xorshift32 step for the card deck block
// no dependencies
package cds_pkg;

  localparam int CARD_W = 6;
  localparam int OP_W = 3;
  localparam int IN_CARD_W = 8;
  localparam int RNG_W = 32;
  localparam int OUT_DW = 16;
  localparam logic [RNG_W-1:0] GOLDEN = 32'h9e3779b9;

  typedef enum logic [OP_W-1:0] {
    OP_FULL    = 3'd0,
    OP_MARK    = 3'd1,
    OP_BUILD   = 3'd2,
    OP_SHUFFLE = 3'd3,
    OP_DEAL    = 3'd4,
    OP_STACK   = 3'd5,
    OP_RESEED  = 3'd6,
    OP_NOP     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    logic start;
    logic reseed;
  } draw_req_t;

  function automatic logic [RNG_W-1:0] xorshift(input logic [RNG_W-1:0] s);
    logic [RNG_W-1:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

@@ rtl/cds_ram.sv @@
// cds_ram: generic simple dual port ram, one write port, one registered read port
// no dependencies
module cds_ram #(
  parameter int W = 6,
  parameter int D = 52,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ rtl/cds_draw.sv @@
// cds_draw: xorshift32 generator with unbiased bounded draw (rejection + bit-serial remainder)
// depends on cds_pkg
module cds_draw import cds_pkg::*; #(
  parameter int NW = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  draw_req_t        req,
  input  logic [NW-1:0]    n,
  input  logic [RNG_W-1:0] seed,
  output logic             done,
  output logic [NW-1:0]    value
);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_BND  = 4'b0010,
    D_GEN  = 4'b0100,
    D_MOD  = 4'b1000
  } dstate_t;

  dstate_t          st_r, st_nxt;
  logic [RNG_W-1:0] rng_r, rng_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [NW-1:0]    rem_r, rem_nxt;
  logic [RNG_W-1:0] dvd_r, dvd_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic [RNG_W-1:0] bound_r, bound_nxt;
  logic             rzero_r, rzero_nxt;
  logic             done_r, done_nxt;
  logic [NW-1:0]    val_r, val_nxt;

  logic [NW:0]      t_w, tsub_w;
  logic [NW-1:0]    rem_step, rp1;
  logic [RNG_W-1:0] xs;

  always_comb begin
    t_w      = {rem_r, dvd_r[RNG_W-1]};
    tsub_w   = t_w - {1'b0, n_r};
    rem_step = (t_w >= {1'b0, n_r}) ? tsub_w[NW-1:0] : t_w[NW-1:0];
    rp1      = rem_step + NW'(1);
    xs       = xorshift(rng_r);

    st_nxt    = st_r;
    rng_nxt   = rng_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    bit_nxt   = bit_r;
    bound_nxt = bound_r;
    rzero_nxt = rzero_r;
    done_nxt  = 1'b0;
    val_nxt   = val_r;

    unique case (st_r)
      D_IDLE: begin
        if (req.reseed) begin
          rng_nxt = (seed != '0) ? seed : GOLDEN;
        end
        if (req.start) begin
          n_nxt   = n;
          dvd_nxt = '1;
          rem_nxt = '0;
          bit_nxt = '0;
          st_nxt  = D_BND;
        end
      end
      // 0xffffffff mod n, then reject count and bound
      D_BND: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_r << 1;
        bit_nxt = bit_r + 5'd1;
        if (bit_r == 5'd31) begin
          rzero_nxt = (rp1 == n_r);
          bound_nxt = '0 - RNG_W'(rp1);
          st_nxt    = D_GEN;
        end
      end
      D_GEN: begin
        rng_nxt = xs;
        if (rzero_r || (xs < bound_r)) begin
          dvd_nxt = xs;
          rem_nxt = '0;
          bit_nxt = '0;
          st_nxt  = D_MOD;
        end
      end
      D_MOD: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_r << 1;
        bit_nxt = bit_r + 5'd1;
        if (bit_r == 5'd31) begin
          done_nxt = 1'b1;
          val_nxt  = rem_step;
          st_nxt   = D_IDLE;
        end
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      rng_r  <= GOLDEN;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      rng_r  <= rng_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    bit_r   <= bit_nxt;
    bound_r <= bound_nxt;
    rzero_r <= rzero_nxt;
    val_r   <= val_nxt;
  end

  assign done  = done_r;
  assign value = val_r;

endmodule

@@ rtl/card_deck_shuffle_deal.sv @@
// card deck with fill, seen marks, shuffle, deal and stacked lists; one item at a time.
// full deck and build walk every card position; shuffle draws each swap index from the
// bit-serial remainder unit (a bound, then a remainder) and draws another generator word on
// each rejection; stack list end collects the undealt cards, checks each listed card and
// searches the deck positions for each listed card.
// results wait in an output register; reset (synchronous, rst_n low) empties the deck,
// clears marks and list, loads the seed constant
module card_deck_shuffle_deal import cds_pkg::*; #(
  parameter int CARDS = 52
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_CARD_W-1:0]  in_tdata,   // [7:0] card
  input  logic [OP_W-1:0]       in_tuser,   // [2:0] operation
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DW-1:0]     out_tdata,  // [5:0] dealt_card, [11:6] remaining
  output logic [2:0]            out_tuser,  // [0] card_valid, [2:1] status
  input  logic                  cfg_wr_en,
  input  logic [RNG_W-1:0]      cfg_wr_data
);

  localparam int IW = $clog2(CARDS);
  localparam int NW = $clog2(CARDS + 1);

  typedef enum logic [21:0] {
    S_IDLE    = 22'h000001,
    S_DISP    = 22'h000002,
    S_FILL    = 22'h000004,
    S_SH_TOP  = 22'h000008,
    S_SH_WAIT = 22'h000010,
    S_SH_RT   = 22'h000020,
    S_SH_RJ   = 22'h000040,
    S_SH_W1   = 22'h000080,
    S_SH_W2   = 22'h000100,
    S_VCHK    = 22'h000200,
    S_AV_RD   = 22'h000400,
    S_AV_CAP  = 22'h000800,
    S_CK_RD   = 22'h001000,
    S_CK_CAP  = 22'h002000,
    S_AP_K    = 22'h004000,
    S_AP_KC   = 22'h008000,
    S_AP_RD   = 22'h010000,
    S_AP_CMP  = 22'h020000,
    S_AP_DR   = 22'h040000,
    S_AP_W1   = 22'h080000,
    S_AP_W2   = 22'h100000,
    S_OUT     = 22'h200000
  } state_t;

  state_t               st_r, st_nxt;
  op_t                  op_r, op_nxt;
  logic [IN_CARD_W-1:0] card_r, card_nxt;
  logic                 last_r, last_nxt;
  logic [NW-1:0]        size_r, size_nxt;
  logic [NW-1:0]        dp_r, dp_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic                 bad_r, bad_nxt;
  logic [CARDS-1:0]     seen_r, seen_nxt;
  logic [CARDS-1:0]     avail_r, avail_nxt;
  logic [NW-1:0]        i_r, i_nxt;
  logic [NW-1:0]        k_r, k_nxt;
  logic [IW-1:0]        pos_r, pos_nxt;
  logic [CARD_W-1:0]    sk_r, sk_nxt;
  logic [CARD_W-1:0]    tmp_r, tmp_nxt;
  logic [RNG_W-1:0]     seed_r;

  logic [CARD_W-1:0]    res_dealt_r, res_dealt_nxt;
  logic                 res_valid_r, res_valid_nxt;
  status_t              res_status_r, res_status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [CARD_W-1:0]    out_dealt_r, out_dealt_nxt;
  logic                 out_cvalid_r, out_cvalid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [CARD_W-1:0]    out_rem_r, out_rem_nxt;

  logic                 d_we, s_we;
  logic [IW-1:0]        d_waddr, d_raddr, s_waddr, s_raddr;
  logic [CARD_W-1:0]    d_wdata, d_rdata, s_wdata, s_rdata;

  draw_req_t            dr_req;
  logic                 dr_done;
  logic [NW-1:0]        dr_val;

  logic                 fin, out_free, out_load;
  logic [CARD_W-1:0]    fin_dealt, ld_dealt;
  logic                 fin_valid, ld_valid;
  status_t              fin_status, ld_status;
  logic [NW-1:0]        n_w, top_w, dst_w, j_w, rem_w;
  logic                 over_w;

  cds_ram #(.W(CARD_W), .D(CARDS)) u_deck (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  cds_ram #(.W(CARD_W), .D(CARDS)) u_list (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  cds_draw #(.NW(NW)) u_draw (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dr_req),
    .n     (n_w),
    .seed  (seed_r),
    .done  (dr_done),
    .value (dr_val)
  );

  assign in_tready = (st_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign n_w       = i_r - dp_r;
  assign top_w     = i_r - NW'(1);
  assign dst_w     = dp_r + k_r;
  assign j_w       = dp_r + dr_val;
  assign over_w    = ({1'b0, dp_r} + {1'b0, cnt_r}) > {1'b0, size_r};

  always_comb begin
    st_nxt    = st_r;
    op_nxt    = op_r;
    card_nxt  = card_r;
    last_nxt  = last_r;
    size_nxt  = size_r;
    dp_nxt    = dp_r;
    cnt_nxt   = cnt_r;
    bad_nxt   = bad_r;
    seen_nxt  = seen_r;
    avail_nxt = avail_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    sk_nxt    = sk_r;
    tmp_nxt   = tmp_r;

    d_we    = 1'b0;
    d_waddr = pos_r;
    d_wdata = tmp_r;
    d_raddr = dp_r[IW-1:0];
    s_we    = 1'b0;
    s_waddr = cnt_r[IW-1:0];
    s_wdata = card_r[CARD_W-1:0];
    s_raddr = k_r[IW-1:0];
    dr_req  = '0;

    fin        = 1'b0;
    fin_dealt  = '0;
    fin_valid  = 1'b0;
    fin_status = ST_OK;

    unique case (st_r)
      S_IDLE: begin
        // deck ram reads deal_position every idle cycle for a deal
        if (in_tvalid) begin
          op_nxt   = op_t'(in_tuser);
          card_nxt = in_tdata;
          last_nxt = in_tlast;
          st_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (op_r)
          OP_FULL: begin
            size_nxt = NW'(CARDS);
            dp_nxt   = '0;
            i_nxt    = '0;
            st_nxt   = S_FILL;
          end
          OP_BUILD: begin
            size_nxt = '0;
            dp_nxt   = '0;
            i_nxt    = '0;
            st_nxt   = S_FILL;
          end
          OP_MARK: begin
            if (card_r < IN_CARD_W'(CARDS)) begin
              seen_nxt[card_r[IW-1:0]] = 1'b1;
            end
            fin = 1'b1;
          end
          OP_SHUFFLE: begin
            i_nxt  = size_r;
            st_nxt = S_SH_TOP;
          end
          OP_DEAL: begin
            if (dp_r >= size_r) begin
              fin_status = ST_EMPTY;
            end else begin
              fin_dealt = d_rdata;
              fin_valid = 1'b1;
              dp_nxt    = dp_r + NW'(1);
            end
            fin = 1'b1;
          end
          OP_STACK: begin
            if (card_r >= IN_CARD_W'(CARDS) || cnt_r >= NW'(CARDS)) begin
              bad_nxt = 1'b1;
            end else begin
              s_we    = 1'b1;
              cnt_nxt = cnt_r + NW'(1);
            end
            if (last_r) begin
              st_nxt = S_VCHK;
            end else begin
              fin = 1'b1;
            end
          end
          OP_RESEED: begin
            dr_req.reseed = 1'b1;
            fin           = 1'b1;
          end
          OP_NOP: fin = 1'b1;
          default: fin = 1'b1;
        endcase
      end
      S_FILL: begin
        if (op_r == OP_FULL) begin
          d_we    = 1'b1;
          d_waddr = i_r[IW-1:0];
          d_wdata = CARD_W'(i_r);
        end else begin
          if (!seen_r[i_r[IW-1:0]]) begin
            d_we     = 1'b1;
            d_waddr  = size_r[IW-1:0];
            d_wdata  = CARD_W'(i_r);
            size_nxt = size_r + NW'(1);
          end
          seen_nxt[i_r[IW-1:0]] = 1'b0;
        end
        i_nxt = i_r + NW'(1);
        if (i_r == NW'(CARDS - 1)) begin
          fin = 1'b1;
        end
      end
      S_SH_TOP: begin
        if (n_w >= NW'(2)) begin
          dr_req.start = 1'b1;
          st_nxt       = S_SH_WAIT;
        end else begin
          fin = 1'b1;
        end
      end
      S_SH_WAIT: begin
        if (dr_done) begin
          pos_nxt = j_w[IW-1:0];
          st_nxt  = S_SH_RT;
        end
      end
      S_SH_RT: begin
        d_raddr = top_w[IW-1:0];
        st_nxt  = S_SH_RJ;
      end
      S_SH_RJ: begin
        tmp_nxt = d_rdata;
        d_raddr = pos_r;
        st_nxt  = S_SH_W1;
      end
      S_SH_W1: begin
        d_we    = 1'b1;
        d_waddr = top_w[IW-1:0];
        d_wdata = d_rdata;
        st_nxt  = S_SH_W2;
      end
      S_SH_W2: begin
        d_we    = 1'b1;
        d_waddr = pos_r;
        d_wdata = tmp_r;
        i_nxt   = top_w;
        st_nxt  = S_SH_TOP;
      end
      S_VCHK: begin
        if (bad_r || over_w) begin
          fin        = 1'b1;
          fin_status = ST_REJECT;
          cnt_nxt    = '0;
          bad_nxt    = 1'b0;
        end else begin
          avail_nxt = '0;
          i_nxt     = dp_r;
          st_nxt    = S_AV_RD;
        end
      end
      // collect undealt cards into a bitmap
      S_AV_RD: begin
        d_raddr = i_r[IW-1:0];
        st_nxt  = S_AV_CAP;
      end
      S_AV_CAP: begin
        avail_nxt[d_rdata[IW-1:0]] = 1'b1;
        i_nxt = i_r + NW'(1);
        if ((i_r + NW'(1)) == size_r) begin
          k_nxt  = '0;
          st_nxt = S_CK_RD;
        end else begin
          st_nxt = S_AV_RD;
        end
      end
      // each listed card consumes its bit, so a duplicate finds it gone
      S_CK_RD: begin
        s_raddr = k_r[IW-1:0];
        st_nxt  = S_CK_CAP;
      end
      S_CK_CAP: begin
        if (!avail_r[s_rdata[IW-1:0]]) begin
          fin        = 1'b1;
          fin_status = ST_REJECT;
          cnt_nxt    = '0;
          bad_nxt    = 1'b0;
        end else begin
          avail_nxt[s_rdata[IW-1:0]] = 1'b0;
          if ((k_r + NW'(1)) == cnt_r) begin
            k_nxt  = '0;
            st_nxt = S_AP_K;
          end else begin
            k_nxt  = k_r + NW'(1);
            st_nxt = S_CK_RD;
          end
        end
      end
      S_AP_K: begin
        s_raddr = k_r[IW-1:0];
        st_nxt  = S_AP_KC;
      end
      S_AP_KC: begin
        sk_nxt = s_rdata;
        i_nxt  = dst_w;
        st_nxt = S_AP_RD;
      end
      S_AP_RD: begin
        d_raddr = i_r[IW-1:0];
        st_nxt  = S_AP_CMP;
      end
      S_AP_CMP: begin
        if (d_rdata == sk_r) begin
          pos_nxt = i_r[IW-1:0];
          st_nxt  = S_AP_DR;
        end else begin
          i_nxt  = i_r + NW'(1);
          st_nxt = S_AP_RD;
        end
      end
      S_AP_DR: begin
        d_raddr = dst_w[IW-1:0];
        st_nxt  = S_AP_W1;
      end
      S_AP_W1: begin
        d_we    = 1'b1;
        d_waddr = pos_r;
        d_wdata = d_rdata;
        st_nxt  = S_AP_W2;
      end
      S_AP_W2: begin
        d_we    = 1'b1;
        d_waddr = dst_w[IW-1:0];
        d_wdata = sk_r;
        k_nxt   = k_r + NW'(1);
        if ((k_r + NW'(1)) == cnt_r) begin
          fin     = 1'b1;
          cnt_nxt = '0;
          bad_nxt = 1'b0;
        end else begin
          st_nxt = S_AP_K;
        end
      end
      S_OUT: begin
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    // result goes straight to the output register when it is free
    res_dealt_nxt  = res_dealt_r;
    res_valid_nxt  = res_valid_r;
    res_status_nxt = res_status_r;
    out_load       = 1'b0;
    ld_dealt       = res_dealt_r;
    ld_valid       = res_valid_r;
    ld_status      = res_status_r;
    if (fin) begin
      ld_dealt  = fin_dealt;
      ld_valid  = fin_valid;
      ld_status = fin_status;
      if (out_free) begin
        out_load = 1'b1;
        st_nxt   = S_IDLE;
      end else begin
        res_dealt_nxt  = fin_dealt;
        res_valid_nxt  = fin_valid;
        res_status_nxt = fin_status;
        st_nxt         = S_OUT;
      end
    end else if (st_r == S_OUT && out_free) begin
      out_load = 1'b1;
    end

    rem_w          = size_nxt - dp_nxt;
    out_dealt_nxt  = out_dealt_r;
    out_cvalid_nxt = out_cvalid_r;
    out_status_nxt = out_status_r;
    out_rem_nxt    = out_rem_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_dealt_nxt  = ld_dealt;
      out_cvalid_nxt = ld_valid;
      out_status_nxt = ld_status;
      out_rem_nxt    = CARD_W'(rem_w);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      size_r      <= '0;
      dp_r        <= '0;
      cnt_r       <= '0;
      bad_r       <= 1'b0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= GOLDEN;
    end else begin
      st_r        <= st_nxt;
      size_r      <= size_nxt;
      dp_r        <= dp_nxt;
      cnt_r       <= cnt_nxt;
      bad_r       <= bad_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    card_r       <= card_nxt;
    last_r       <= last_nxt;
    avail_r      <= avail_nxt;
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    pos_r        <= pos_nxt;
    sk_r         <= sk_nxt;
    tmp_r        <= tmp_nxt;
    res_dealt_r  <= res_dealt_nxt;
    res_valid_r  <= res_valid_nxt;
    res_status_r <= res_status_nxt;
    out_dealt_r  <= out_dealt_nxt;
    out_cvalid_r <= out_cvalid_nxt;
    out_status_r <= out_status_nxt;
    out_rem_r    <= out_rem_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW - 2 * CARD_W)'(0), out_rem_r, out_dealt_r};
  assign out_tuser  = {out_status_r, out_cvalid_r};

  a_dp_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    dp_r <= size_r)
    else $error("deal position past deck size");

  a_draw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SH_WAIT) && dr_done |-> dr_val < n_w)
    else $error("draw result not below bound");

  a_deck_waddr: assert property (@(posedge clk) disable iff (!rst_n)
    d_we |-> int'(d_waddr) < CARDS)
    else $error("deck write outside store");

  a_card_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cvalid_r |-> out_status_r == ST_OK)
    else $error("dealt card with error status");

endmodule
